// ===== hw/rtl/mpbm_pkg.sv =====
package mpbm_pkg;

  localparam int unsigned ALPHA_W    = 7;
  localparam int unsigned ALPHABET   = 128;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TAG_W      = 64;
  localparam int unsigned BASE_W     = 48;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned PNUM_W     = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 152;

  typedef enum logic [1:0] {
    REQ_PATTERN = 2'd0,
    REQ_BUILD   = 2'd1,
    REQ_START   = 2'd2,
    REQ_TEXT    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    BST_OK       = 2'd0,
    BST_EMPTY    = 2'd1,
    BST_OVERFLOW = 2'd2
  } build_status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_MATCH  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLR_ROOT, OP_SET_OVF,
    OP_L_RD, OP_L_STEP, OP_L_ALLOC, OP_L_NEW, OP_L_MASK,
    OP_BCHK, OP_START,
    OP_B_INIT, OP_B_RD, OP_B_WR, OP_B_POP, OP_B_FRD, OP_B_FSET, OP_B_DONE,
    OP_EMIT_STATUS,
    OP_S_RD, OP_S_STEP, OP_S_LOADM, OP_S_TAKE, OP_S_CHAIN, OP_S_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic built;
    logic ovf;
    logic pc_zero;
    logic pc_full;
    logic child;
    logic nc_full;
    logic last;
    logic c_last;
    logic q_empty;
    logic node_zero;
    logic mask_zero;
    logic next_zero;
    logic hold_valid;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/multi_pattern_byte_matcher.sv =====
// text byte: no result when it lands on the root, else one result per match found along
//   the failure chain
// build: visits all 128 bytes of every trie node in breadth-first order
// throughput: one request at a time; a new request is taken once the previous one is done
// reset: synchronous active-low; after reset the init state clears the root row of the trie
//   before the first request is taken
module multi_pattern_byte_matcher #(
  parameter int unsigned MAX_NODES    = 256,
  parameter int unsigned MAX_PATTERNS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mpbm_pkg::IN_DATA_W-1:0]  in_tdata,   // data_byte, chunk_tag, base_offset
  input  logic [1:0]                      in_tuser,   // req_type
  input  logic                            in_tlast,   // pattern_end
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mpbm_pkg::OUT_DATA_W-1:0] out_tdata,  // build_status, pattern_number,
                                                      // match_position, chunk_tag_out,
                                                      // absolute_offset, zero pad
  output logic                            out_tuser,  // result_kind
  output logic                            out_tlast   // last_of_run
);
  import mpbm_pkg::*;

  // controller issues one datapath operation per cycle and branches on status
  dp_cmd_t    cmd;
  dp_status_t sts;

  mpbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds the trie tables, bfs queue, scan state and the output register
  mpbm_dp #(
    .MAX_NODES    (MAX_NODES),
    .MAX_PATTERNS (MAX_PATTERNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/mpbm_dp.sv =====
module mpbm_dp #(
  parameter int unsigned MAX_NODES    = 256,
  parameter int unsigned MAX_PATTERNS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpbm_pkg::dp_cmd_t             cmd,
  output mpbm_pkg::dp_status_t          sts,
  input  logic [1:0]                    in_tuser,
  input  logic                          in_tlast,
  input  logic [mpbm_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tuser,
  output logic                          out_tlast,
  output logic [mpbm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mpbm_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = NW + 1;
  localparam int unsigned LW  = NW + 1;
  localparam int unsigned MP  = MAX_PATTERNS;
  localparam int unsigned PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned PCW = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned TA  = NW + ALPHA_W;

  // latched request
  req_t                in_req_r;
  logic [ALPHA_W-1:0]  in_c_r;
  logic                in_last_r;
  logic [TAG_W-1:0]    in_tag_r;
  logic [BASE_W-1:0]   in_base_r;

  logic [NCW-1:0]      node_count_r;
  logic [PCW-1:0]      pcount_r;
  logic [NW-1:0]       cursor_r;
  logic                built_r;
  logic                ovf_r;
  logic [NW-1:0]       scan_r;
  logic [POS_W-1:0]    spos_r;
  logic [TAG_W-1:0]    chunk_r;
  logic [BASE_W-1:0]   base_r;
  logic [LW-1:0]       len_r [MP];
  build_status_t       status_r;

  logic [NW-1:0]       bu_r;
  logic [NW-1:0]       bf_r;
  logic                broot_r;
  logic [ALPHA_W-1:0]  bc_r;
  logic [NCW-1:0]      head_r;
  logic [NCW-1:0]      tail_r;

  logic [NW-1:0]       node_r;
  logic [MP-1:0]       mask_r;
  logic [POS_W-1:0]    epos_r;
  logic                hold_valid_r;
  logic [PW-1:0]       hold_p_r;
  logic [POS_W-1:0]    hold_pos_r;

  logic                    ov_r;
  logic                    okind_r;
  logic                    olast_r;
  logic [STATUS_W-1:0]     ostat_r;
  logic [PNUM_W-1:0]       opnum_r;
  logic [POS_W-1:0]        opos_r;
  logic [TAG_W-1:0]        otag_r;
  logic [BASE_W-1:0]       oabs_r;

  // memories
  logic [NW-1:0]       trans_mem [MAX_NODES*ALPHABET];
  logic [ALPHABET-1:0] cp_mem    [MAX_NODES];
  logic [NW-1:0]       fail_mem  [MAX_NODES];
  logic [MP-1:0]       mask_mem  [MAX_NODES];
  logic [NW-1:0]       q_mem     [MAX_NODES];

  logic [NW-1:0]       ta_q, tb_q, fail_q, q_q;
  logic [ALPHABET-1:0] cp_q;
  logic [MP-1:0]       mask_q;

  logic                tw_en, cpw_en, fw_en, mw_en, qw_en;
  logic [TA-1:0]       tw_addr, ta_addr, tb_addr;
  logic [NW-1:0]       tw_data;
  logic [NW-1:0]       cpw_addr, cp_raddr;
  logic [ALPHABET-1:0] cpw_data;
  logic [NW-1:0]       fw_addr, fw_data, f_raddr;
  logic [NW-1:0]       mw_addr, m_raddr;
  logic [MP-1:0]       mw_data;
  logic [NW-1:0]       qw_addr, qw_data, q_raddr;

  logic [PW-1:0]       pidx;
  logic [MP-1:0]       pbit;
  logic [LW-1:0]       len_upd;
  logic [NW-1:0]       tf;
  logic [PW-1:0]       low_p;
  logic                out_free;

  assign pidx    = PW'(pcount_r);
  assign pbit    = MP'(1) << pidx;
  assign len_upd = (cursor_r == '0) ? LW'(1) : len_r[pidx] + LW'(1);
  assign tf      = broot_r ? '0 : tb_q;
  assign out_free = !ov_r || out_tready;

  always_comb begin
    low_p = '0;
    for (int i = MP - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_p = PW'(i);
      end
    end
  end

  always_comb begin
    tw_en = 1'b0; cpw_en = 1'b0; fw_en = 1'b0; mw_en = 1'b0; qw_en = 1'b0;
    tw_addr = {cursor_r, in_c_r};
    tw_data = NW'(node_count_r);
    ta_addr = {cursor_r, in_c_r};
    tb_addr = {bf_r, bc_r};
    cpw_addr = cursor_r;
    cpw_data = cp_q | (ALPHABET'(1) << in_c_r);
    cp_raddr = cursor_r;
    fw_addr = ta_q;
    fw_data = tf;
    f_raddr = ta_q;
    mw_addr = NW'(node_count_r);
    mw_data = in_last_r ? pbit : '0;
    m_raddr = ta_q;
    qw_addr = NW'(tail_r);
    qw_data = ta_q;
    q_raddr = NW'(head_r);
    unique case (cmd.op)
      OP_CLR_ROOT: begin
        cpw_en = 1'b1; cpw_addr = '0; cpw_data = '0;
      end
      OP_L_ALLOC: begin
        cpw_en = 1'b1; tw_en = 1'b1;
      end
      OP_L_NEW: begin
        cpw_en = 1'b1; cpw_addr = NW'(node_count_r); cpw_data = '0;
        mw_en = 1'b1;
      end
      OP_L_MASK: begin
        mw_en = 1'b1; mw_addr = node_r; mw_data = mask_q | pbit;
      end
      OP_B_INIT: cp_raddr = '0;
      OP_B_RD: begin
        ta_addr = {bu_r, bc_r}; cp_raddr = bu_r;
      end
      OP_B_WR: begin
        if (cp_q[bc_r]) begin
          fw_en = 1'b1; qw_en = 1'b1;
        end else begin
          tw_en = 1'b1; tw_addr = {bu_r, bc_r}; tw_data = tf;
        end
      end
      OP_B_FRD: begin
        f_raddr = q_q; cp_raddr = q_q;
      end
      OP_S_RD: ta_addr = {scan_r, in_c_r};
      OP_S_CHAIN: begin
        f_raddr = node_r; m_raddr = node_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tw_en) trans_mem[tw_addr] <= tw_data;
    ta_q <= trans_mem[ta_addr];
    tb_q <= trans_mem[tb_addr];
  end

  always_ff @(posedge clk) begin
    if (cpw_en) cp_mem[cpw_addr] <= cpw_data;
    cp_q <= cp_mem[cp_raddr];
  end

  always_ff @(posedge clk) begin
    if (fw_en) fail_mem[fw_addr] <= fw_data;
    fail_q <= fail_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (mw_en) mask_mem[mw_addr] <= mw_data;
    mask_q <= mask_mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (qw_en) q_mem[qw_addr] <= qw_data;
    q_q <= q_mem[q_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        in_req_r  <= req_t'(in_tuser);
        in_c_r    <= in_tdata[7] ? '0 : in_tdata[ALPHA_W-1:0];
        in_last_r <= in_tlast;
        in_tag_r  <= in_tdata[71:8];
        in_base_r <= in_tdata[119:72];
      end
      OP_L_STEP: begin
        len_r[pidx] <= len_upd;
        node_r      <= ta_q;
      end
      OP_L_NEW: len_r[pidx] <= len_upd;
      OP_BCHK: status_r <= ovf_r ? BST_OVERFLOW : BST_EMPTY;
      OP_B_DONE: status_r <= BST_OK;
      OP_B_INIT: begin
        bu_r <= '0; bf_r <= '0; broot_r <= 1'b1; bc_r <= '0;
      end
      OP_B_WR: bc_r <= bc_r + ALPHA_W'(1);
      OP_B_FRD: begin
        bu_r <= q_q; broot_r <= 1'b0; bc_r <= '0;
      end
      OP_B_FSET: bf_r <= fail_q;
      OP_S_STEP: begin
        node_r <= ta_q; epos_r <= spos_r;
      end
      OP_S_LOADM: begin
        mask_r <= mask_q; node_r <= fail_q;
      end
      OP_S_TAKE: begin
        mask_r     <= mask_r & ~(MP'(1) << low_p);
        hold_p_r   <= low_p;
        hold_pos_r <= epos_r - POS_W'(len_r[low_p]) + POS_W'(1);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCW'(1);
      pcount_r     <= '0;
      cursor_r     <= '0;
      built_r      <= 1'b0;
      ovf_r        <= 1'b0;
      scan_r       <= '0;
      spos_r       <= '0;
      chunk_r      <= '0;
      base_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CLR_ROOT: begin
          node_count_r <= NCW'(1); pcount_r <= '0; cursor_r <= '0;
          scan_r <= '0; built_r <= 1'b0;
        end
        OP_SET_OVF: ovf_r <= 1'b1;
        OP_L_STEP:  cursor_r <= ta_q;
        OP_L_NEW: begin
          node_count_r <= node_count_r + NCW'(1);
          cursor_r     <= in_last_r ? '0 : NW'(node_count_r);
          if (in_last_r) pcount_r <= pcount_r + PCW'(1);
        end
        OP_L_MASK: begin
          pcount_r <= pcount_r + PCW'(1); cursor_r <= '0;
        end
        OP_BCHK: begin
          cursor_r <= '0;
          if (ovf_r || pcount_r == '0) built_r <= 1'b0;
        end
        OP_START: begin
          scan_r <= '0; spos_r <= '0; chunk_r <= in_tag_r; base_r <= in_base_r;
        end
        OP_B_INIT: begin
          head_r <= '0; tail_r <= '0;
        end
        OP_B_WR:  if (cp_q[bc_r]) tail_r <= tail_r + NCW'(1);
        OP_B_POP: head_r <= head_r + NCW'(1);
        OP_B_DONE: begin
          built_r <= 1'b1; scan_r <= '0;
        end
        OP_S_STEP: begin
          scan_r <= ta_q; spos_r <= spos_r + POS_W'(1);
        end
        OP_S_TAKE:  hold_valid_r <= 1'b1;
        OP_S_FLUSH: hold_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // output register
  logic emit_status, emit_hold;
  assign emit_status = (cmd.op == OP_EMIT_STATUS);
  assign emit_hold   = (cmd.op == OP_S_FLUSH) || (cmd.op == OP_S_TAKE && hold_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_status || emit_hold) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_status) begin
      okind_r <= KIND_STATUS;
      ostat_r <= status_r;
      opnum_r <= '0;
      opos_r  <= '0;
      otag_r  <= '0;
      oabs_r  <= '0;
      olast_r <= 1'b1;
    end else if (emit_hold) begin
      okind_r <= KIND_MATCH;
      ostat_r <= BST_OK;
      opnum_r <= PNUM_W'(hold_p_r);
      opos_r  <= hold_pos_r;
      otag_r  <= chunk_r;
      oabs_r  <= base_r + BASE_W'(hold_pos_r);
      olast_r <= (cmd.op == OP_S_FLUSH);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {2'b00, oabs_r, otag_r, opos_r, opnum_r, ostat_r};

  always_comb begin
    sts.req        = in_req_r;
    sts.built      = built_r;
    sts.ovf        = ovf_r;
    sts.pc_zero    = (pcount_r == '0);
    sts.pc_full    = (pcount_r >= PCW'(MAX_PATTERNS));
    sts.child      = cp_q[in_c_r];
    sts.nc_full    = (node_count_r >= NCW'(MAX_NODES));
    sts.last       = in_last_r;
    sts.c_last     = (bc_r == '1);
    sts.q_empty    = (head_r == tail_r);
    sts.node_zero  = (ta_q == '0);
    sts.mask_zero  = (mask_r == '0);
    sts.next_zero  = (node_r == '0);
    sts.hold_valid = hold_valid_r;
    sts.out_free   = out_free;
  end

  a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r != '0 && node_count_r <= NCW'(MAX_NODES))
    else $error("node count out of range");

  a_pattern_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PCW'(MAX_PATTERNS))
    else $error("pattern count out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("bfs head passed tail");

endmodule

// ===== hw/rtl/mpbm_ctrl.sv =====
module mpbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  mpbm_pkg::dp_status_t sts,
  output mpbm_pkg::dp_cmd_t    cmd
);
  import mpbm_pkg::*;

  typedef enum logic [17:0] {
    S_INIT   = 18'h00001,
    S_IDLE   = 18'h00002,
    S_DISP   = 18'h00004,
    S_LCHK   = 18'h00008,
    S_LDEC   = 18'h00010,
    S_LNEW   = 18'h00020,
    S_LMASK  = 18'h00040,
    S_BINIT  = 18'h00080,
    S_BRD    = 18'h00100,
    S_BWR    = 18'h00200,
    S_BNEXT  = 18'h00400,
    S_BFAIL  = 18'h00800,
    S_BLOAD  = 18'h01000,
    S_BSTAT  = 18'h02000,
    S_SSTEP  = 18'h04000,
    S_SMASK  = 18'h08000,
    S_SEMIT  = 18'h10000,
    S_SFLUSH = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_CLR_ROOT; state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = OP_ACCEPT; state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req)
          REQ_PATTERN: begin
            if (sts.built) cmd.op = OP_CLR_ROOT;
            state_nxt = S_LCHK;
          end
          REQ_BUILD: begin
            cmd.op = OP_BCHK;
            state_nxt = (sts.ovf || sts.pc_zero) ? S_BSTAT : S_BINIT;
          end
          REQ_START: begin
            cmd.op = OP_START; state_nxt = S_IDLE;
          end
          REQ_TEXT: begin
            if (sts.built) begin
              cmd.op = OP_S_RD; state_nxt = S_SSTEP;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LCHK: begin
        priority if (sts.ovf) begin
          state_nxt = S_IDLE;
        end else if (sts.pc_full) begin
          cmd.op = OP_SET_OVF; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_L_RD; state_nxt = S_LDEC;
        end
      end
      S_LDEC: begin
        priority if (sts.child) begin
          cmd.op = OP_L_STEP; state_nxt = sts.last ? S_LMASK : S_IDLE;
        end else if (sts.nc_full) begin
          cmd.op = OP_SET_OVF; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_L_ALLOC; state_nxt = S_LNEW;
        end
      end
      S_LNEW: begin
        cmd.op = OP_L_NEW; state_nxt = S_IDLE;
      end
      S_LMASK: begin
        cmd.op = OP_L_MASK; state_nxt = S_IDLE;
      end
      S_BINIT: begin
        cmd.op = OP_B_INIT; state_nxt = S_BRD;
      end
      S_BRD: begin
        cmd.op = OP_B_RD; state_nxt = S_BWR;
      end
      S_BWR: begin
        cmd.op = OP_B_WR; state_nxt = sts.c_last ? S_BNEXT : S_BRD;
      end
      S_BNEXT: begin
        if (sts.q_empty) begin
          cmd.op = OP_B_DONE; state_nxt = S_BSTAT;
        end else begin
          cmd.op = OP_B_POP; state_nxt = S_BFAIL;
        end
      end
      S_BFAIL: begin
        cmd.op = OP_B_FRD; state_nxt = S_BLOAD;
      end
      S_BLOAD: begin
        cmd.op = OP_B_FSET; state_nxt = S_BRD;
      end
      S_BSTAT: begin
        if (sts.out_free) begin
          cmd.op = OP_EMIT_STATUS; state_nxt = S_IDLE;
        end
      end
      S_SSTEP: begin
        cmd.op = OP_S_STEP; state_nxt = sts.node_zero ? S_IDLE : S_SMASK;
      end
      S_SMASK: begin
        cmd.op = OP_S_LOADM; state_nxt = S_SEMIT;
      end
      S_SEMIT: begin
        priority if (!sts.mask_zero) begin
          if (!sts.hold_valid || sts.out_free) cmd.op = OP_S_TAKE;
        end else if (sts.next_zero) begin
          state_nxt = S_SFLUSH;
        end else begin
          cmd.op = OP_S_CHAIN; state_nxt = S_SMASK;
        end
      end
      S_SFLUSH: begin
        priority if (!sts.hold_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.op = OP_S_FLUSH; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_DISP)
    else $error("accepted request not dispatched");

  a_flush_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_S_FLUSH |-> sts.hold_valid && sts.out_free)
    else $error("flush without held result");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_S_TAKE && sts.hold_valid) |-> sts.out_free)
    else $error("result emitted into full output register");

endmodule
